// File: rtl/vau_pkg.sv
`default_nettype none

package vau_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int SQ_STAGES     = 32;

    typedef logic signed [31:0] q_t;
    typedef logic signed [63:0] prod_t;

    localparam q_t Q_MAX = 32'sh7fff_ffff;
    localparam q_t Q_MIN = 32'sh8000_0000;

    typedef enum logic [3:0] {
        ACT_ADD  = 4'd0,
        ACT_SUB  = 4'd1,
        ACT_NEG  = 4'd2,
        ACT_SCL  = 4'd3,
        ACT_DIV  = 4'd4,
        ACT_CRS  = 4'd5,
        ACT_DOT  = 4'd6,
        ACT_MAG  = 4'd7,
        ACT_NORM = 4'd8,
        ACT_DIST = 4'd9
    } vau_act_t;

    typedef struct packed {
        logic [3:0] action;
        q_t         ax;
        q_t         ay;
        q_t         az;
        q_t         bx;
        q_t         by;
        q_t         bz;
        q_t         scalar;
    } vau_in_t;

    typedef struct packed {
        q_t   rx;
        q_t   ry;
        q_t   rz;
        q_t   rs;
        logic saturated;
    } vau_out_t;

    // per-item context carried down the pipe
    typedef struct packed {
        logic [3:0]       action;
        logic             flag;
        logic             norm_ok;
        q_t [2:0]         r;
        q_t               rs;
        logic [2:0][31:0] amag;
        logic [2:0]       aneg;
        logic [31:0]      smag;
        logic             sneg;
        logic             szero;
    } vau_ctx_t;

    typedef struct packed {
        vau_ctx_t ctx;
        q_t [2:0] a;
        q_t [2:0] b;
        q_t [2:0] d;
        q_t       s;
    } vau_mul_in_t;

    typedef struct packed {
        vau_ctx_t    ctx;
        prod_t [8:0] p;
    } vau_prod_t;

    function automatic q_t sat66(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return Q_MAX;
        if (v < -66'sd2147483648)
            return Q_MIN;
        return v[31:0];
    endfunction

    function automatic logic ovf66(input logic signed [65:0] v);
        return (v > 66'sd2147483647) || (v < -66'sd2147483648);
    endfunction

endpackage

`default_nettype wire

// File: rtl/vector3_arith_unit_core.sv
`default_nettype none

// channel   | signals                          | word
// ----------+----------------------------------+-----------------------------------
// in        | in_valid, in_ready, in_data      | vau_in_t: action, a, b, scalar
// out       | out_valid, out_ready, out_data   | vau_out_t: rx, ry, rz, rs, saturated
// cfg       | cfg_valid, cfg_ready, cfg_data   | 16-bit min_length (always ready)
//
// One word enters per cycle unless a waiting result stalls the pipe; words
// pass through the 32-stage square root followed by the
// (32 + FRAC_BITS)-stage divider.
// Reset clears all valid bits and sets min_length to 1.
// A waiting result stalls every stage at once; the input stage still takes
// a word while it is empty, so nothing is dropped or repeated.
module vector3_arith_unit_core import vau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  vau_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output vau_out_t    out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int QW = WORD_W + FRAC_BITS;

    // global advance: the output register is free or being drained
    logic adv;

    logic [15:0] min_length_reg;

    // stage 1: input capture
    logic    p1_valid_reg;
    vau_in_t p1_item_reg;

    // stage 2: add / sub / negate / difference, operand prep
    vau_mul_in_t p2_next;
    vau_mul_in_t p2_reg;
    logic        p2_valid_reg;
    q_t [2:0]    av;
    q_t [2:0]    bv;
    logic signed [65:0] s2_sum [3];
    logic signed [65:0] s2_dif [3];
    logic signed [65:0] s2_neg [3];

    // stage 3: products
    logic      mul_valid;
    vau_prod_t mul_prod;

    // stage 4: product shift, sums, square sum
    prod_t              shf [9];
    logic signed [65:0] t_crs [3];
    logic signed [65:0] t_dot;
    vau_ctx_t           p3_ctx_next;
    logic [63:0]        p3_sq_next;
    vau_ctx_t           p3_ctx_reg;
    logic [63:0]        p3_sq_reg;
    logic               p3_valid_reg;

    // square root pipe
    logic        sq_valid;
    vau_ctx_t    sq_ctx;
    logic [31:0] sq_root;

    // post-root stage: length results, divisor select
    vau_ctx_t    p5_ctx_next;
    logic [31:0] p5_div_next;
    vau_ctx_t    p5_ctx_reg;
    logic [31:0] p5_div_reg;
    logic        p5_valid_reg;

    // divider pipe
    logic              div_valid;
    vau_ctx_t          div_ctx;
    logic [2:0][QW-1:0] div_quo;

    // final stage
    vau_ctx_t      fin_ctx;
    logic [2:0]    fin_neg;
    logic [2:0]    fin_big;
    q_t [2:0]      fin_val;
    logic [QW-1:0] fin_lim [3];
    vau_out_t      out_next;
    vau_out_t      out_reg;
    logic          out_valid_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv || !p1_valid_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_length_reg <= 16'd1;
        else if (cfg_valid)
            min_length_reg <= cfg_data;
    end

    // ---------------- stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (in_ready)
            p1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            p1_item_reg <= in_data;
    end

    // ---------------- stage 2
    always_comb
    begin
        av = {p1_item_reg.az, p1_item_reg.ay, p1_item_reg.ax};
        bv = {p1_item_reg.bz, p1_item_reg.by, p1_item_reg.bx};
        p2_next.a = av;
        p2_next.b = bv;
        p2_next.s = p1_item_reg.scalar;
        p2_next.ctx.action  = p1_item_reg.action;
        p2_next.ctx.flag    = 1'b0;
        p2_next.ctx.norm_ok = 1'b0;
        p2_next.ctx.r       = '0;
        p2_next.ctx.rs      = '0;
        p2_next.ctx.smag    = p1_item_reg.scalar[31] ? 32'(-p1_item_reg.scalar)
                                                     : 32'(p1_item_reg.scalar);
        p2_next.ctx.sneg    = p1_item_reg.scalar[31];
        p2_next.ctx.szero   = (p1_item_reg.scalar == '0);
        for (int l = 0; l < 3; l++)
        begin
            s2_sum[l] = 66'(av[l]) + 66'(bv[l]);
            s2_dif[l] = 66'(av[l]) - 66'(bv[l]);
            s2_neg[l] = -66'(av[l]);
            p2_next.d[l]        = sat66(s2_dif[l]);
            p2_next.ctx.amag[l] = av[l][31] ? 32'(-av[l]) : 32'(av[l]);
            p2_next.ctx.aneg[l] = av[l][31];
        end
        case (p1_item_reg.action)
            ACT_ADD:
                for (int l = 0; l < 3; l++)
                begin
                    p2_next.ctx.r[l] = sat66(s2_sum[l]);
                    p2_next.ctx.flag = p2_next.ctx.flag | ovf66(s2_sum[l]);
                end
            ACT_SUB:
                for (int l = 0; l < 3; l++)
                begin
                    p2_next.ctx.r[l] = sat66(s2_dif[l]);
                    p2_next.ctx.flag = p2_next.ctx.flag | ovf66(s2_dif[l]);
                end
            ACT_NEG:
                for (int l = 0; l < 3; l++)
                begin
                    p2_next.ctx.r[l] = sat66(s2_neg[l]);
                    p2_next.ctx.flag = p2_next.ctx.flag | ovf66(s2_neg[l]);
                end
            ACT_DIST:
                // difference is clipped before its length is taken
                for (int l = 0; l < 3; l++)
                    p2_next.ctx.flag = p2_next.ctx.flag | ovf66(s2_dif[l]);
            default:
                p2_next.ctx.flag = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_valid_reg <= 1'b0;
        else if (adv)
            p2_valid_reg <= p1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            p2_reg <= p2_next;
    end

    // ---------------- stage 3
    vau_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .vld_in  (p2_valid_reg),
        .op      (p2_reg),
        .vld_out (mul_valid),
        .prod    (mul_prod)
    );

    // ---------------- stage 4
    always_comb
    begin
        for (int k = 0; k < 9; k++)
            shf[k] = mul_prod.p[k] >>> FRAC_BITS;   // floor toward minus infinity
        t_crs[0] = 66'(shf[3]) - 66'(shf[4]);
        t_crs[1] = 66'(shf[5]) - 66'(shf[6]);
        t_crs[2] = 66'(shf[7]) - 66'(shf[8]);
        t_dot    = 66'(shf[0]) + 66'(shf[1]) + 66'(shf[2]);
        // squares are nonnegative and their sum stays below 2^64
        p3_sq_next = 64'($unsigned(mul_prod.p[0])) + 64'($unsigned(mul_prod.p[1]))
                   + 64'($unsigned(mul_prod.p[2]));
        p3_ctx_next = mul_prod.ctx;
        case (mul_prod.ctx.action)
            ACT_SCL:
                for (int l = 0; l < 3; l++)
                begin
                    p3_ctx_next.r[l] = sat66(66'(shf[l]));
                    p3_ctx_next.flag = p3_ctx_next.flag | ovf66(66'(shf[l]));
                end
            ACT_CRS:
                for (int l = 0; l < 3; l++)
                begin
                    p3_ctx_next.r[l] = sat66(t_crs[l]);
                    p3_ctx_next.flag = p3_ctx_next.flag | ovf66(t_crs[l]);
                end
            ACT_DOT:
            begin
                p3_ctx_next.rs   = sat66(t_dot);
                p3_ctx_next.flag = ovf66(t_dot);
            end
            default:
                p3_ctx_next.rs = mul_prod.ctx.rs;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p3_valid_reg <= 1'b0;
        else if (adv)
            p3_valid_reg <= mul_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p3_ctx_reg <= p3_ctx_next;
            p3_sq_reg  <= p3_sq_next;
        end
    end

    // ---------------- square root
    vau_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .vld_in   (p3_valid_reg),
        .ctx_in   (p3_ctx_reg),
        .sq_in    (p3_sq_reg),
        .vld_out  (sq_valid),
        .ctx_out  (sq_ctx),
        .root_out (sq_root)
    );

    // ---------------- post-root stage
    always_comb
    begin
        p5_ctx_next = sq_ctx;
        p5_ctx_next.norm_ok = sq_root > {16'd0, min_length_reg};
        case (sq_ctx.action)
            ACT_MAG, ACT_DIST:
            begin
                p5_ctx_next.rs   = sq_root[31] ? Q_MAX : $signed(sq_root);
                p5_ctx_next.flag = sq_ctx.flag | sq_root[31];
            end
            default:
                p5_ctx_next.rs = sq_ctx.rs;
        endcase
        p5_div_next = (sq_ctx.action == ACT_NORM) ? sq_root : sq_ctx.smag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p5_valid_reg <= 1'b0;
        else if (adv)
            p5_valid_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p5_ctx_reg <= p5_ctx_next;
            p5_div_reg <= p5_div_next;
        end
    end

    // ---------------- divider
    vau_div #(
        .FRAC_BITS (FRAC_BITS),
        .QW        (QW)
    ) u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .vld_in  (p5_valid_reg),
        .ctx_in  (p5_ctx_reg),
        .div_in  (p5_div_reg),
        .vld_out (div_valid),
        .ctx_out (div_ctx),
        .quo_out (div_quo)
    );

    // ---------------- final stage: sign, clip, divide-by-zero
    always_comb
    begin
        fin_ctx = div_ctx;
        for (int l = 0; l < 3; l++)
        begin
            fin_neg[l] = div_ctx.aneg[l] ^ ((div_ctx.action == ACT_DIV) && div_ctx.sneg);
            fin_lim[l] = fin_neg[l] ? QW'(64'h8000_0000) : QW'(64'h7fff_ffff);
            fin_big[l] = div_quo[l] > fin_lim[l];
            if (fin_big[l])
                fin_val[l] = fin_neg[l] ? Q_MIN : Q_MAX;
            else if (fin_neg[l])
                fin_val[l] = $signed(-div_quo[l][31:0]);
            else
                fin_val[l] = $signed(div_quo[l][31:0]);
        end
        case (div_ctx.action)
            ACT_DIV:
                for (int l = 0; l < 3; l++)
                begin
                    if (div_ctx.szero)
                    begin
                        // zero divisor: clip by the sign of the component
                        if (div_ctx.aneg[l])
                            fin_ctx.r[l] = Q_MIN;
                        else if (div_ctx.amag[l] != '0)
                            fin_ctx.r[l] = Q_MAX;
                        else
                            fin_ctx.r[l] = '0;
                        fin_ctx.flag = 1'b1;
                    end
                    else
                    begin
                        fin_ctx.r[l] = fin_val[l];
                        fin_ctx.flag = fin_ctx.flag | fin_big[l];
                    end
                end
            ACT_NORM:
                for (int l = 0; l < 3; l++)
                    fin_ctx.r[l] = div_ctx.norm_ok ? fin_val[l] : '0;
            default:
                fin_ctx.r = div_ctx.r;
        endcase
        out_next.rx        = fin_ctx.r[0];
        out_next.ry        = fin_ctx.r[1];
        out_next.rz        = fin_ctx.r[2];
        out_next.rs        = fin_ctx.rs;
        out_next.saturated = fin_ctx.flag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // ---------------- checks
    // normalize never clips
    a_norm_no_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (div_valid && div_ctx.action == ACT_NORM) |-> !div_ctx.flag)
        else $error("normalize word reached divider output with flag set");

    // scalar actions leave the vector zero all the way down the pipe
    a_scalar_vec_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (div_valid && (div_ctx.action == ACT_DOT || div_ctx.action == ACT_MAG
                       || div_ctx.action == ACT_DIST)) |-> (div_ctx.r == '0))
        else $error("scalar action carries a nonzero vector");

    // an accepted word always lands in the input stage
    a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> p1_valid_reg)
        else $error("accepted input word not captured");

endmodule

`default_nettype wire

// File: rtl/vau_mul.sv
`default_nettype none

// product stage: nine 32x32 multipliers; the first three take operands picked by action, the other six cross products
module vau_mul import vau_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        vld_in,
    input  vau_mul_in_t op,
    output logic        vld_out,
    output vau_prod_t   prod
);

    q_t        xs [9];
    q_t        ys [9];
    vau_prod_t prod_next;
    logic      vld_reg;
    vau_prod_t prod_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            case (op.ctx.action)
                ACT_SCL:
                begin
                    xs[k] = op.a[k];
                    ys[k] = op.s;
                end
                ACT_DOT:
                begin
                    xs[k] = op.a[k];
                    ys[k] = op.b[k];
                end
                ACT_DIST:
                begin
                    xs[k] = op.d[k];
                    ys[k] = op.d[k];
                end
                default:
                begin
                    xs[k] = op.a[k];
                    ys[k] = op.a[k];
                end
            endcase
        end
        xs[3] = op.a[1]; ys[3] = op.b[2];
        xs[4] = op.a[2]; ys[4] = op.b[1];
        xs[5] = op.a[2]; ys[5] = op.b[0];
        xs[6] = op.a[0]; ys[6] = op.b[2];
        xs[7] = op.a[0]; ys[7] = op.b[1];
        xs[8] = op.a[1]; ys[8] = op.b[0];
        prod_next.ctx = op.ctx;
        for (int k = 0; k < 9; k++)
            prod_next.p[k] = xs[k] * ys[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= prod_next;
    end

    assign vld_out = vld_reg;
    assign prod    = prod_reg;

endmodule

`default_nettype wire

// File: rtl/vau_sqrt.sv
`default_nettype none

// floor square root of a 64-bit value, one root bit per stage
module vau_sqrt import vau_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        vld_in,
    input  vau_ctx_t    ctx_in,
    input  logic [63:0] sq_in,
    output logic        vld_out,
    output vau_ctx_t    ctx_out,
    output logic [31:0] root_out
);

    logic        vld_reg  [SQ_STAGES];
    vau_ctx_t    ctx_reg  [SQ_STAGES];
    logic [63:0] rem_reg  [SQ_STAGES];
    logic [31:0] root_reg [SQ_STAGES];

    for (genvar s = 0; s < SQ_STAGES; s++)
    begin : g_stage
        localparam int K = SQ_STAGES - 1 - s;
        logic        src_vld;
        vau_ctx_t    src_ctx;
        logic [63:0] src_rem;
        logic [31:0] src_root;
        logic [64:0] trial;
        logic        take;

        if (s == 0)
        begin : g_first
            assign src_vld  = vld_in;
            assign src_ctx  = ctx_in;
            assign src_rem  = sq_in;
            assign src_root = '0;
        end
        else
        begin : g_next
            assign src_vld  = vld_reg[s-1];
            assign src_ctx  = ctx_reg[s-1];
            assign src_rem  = rem_reg[s-1];
            assign src_root = root_reg[s-1];
        end

        // (root + 2^K)^2 - root^2
        assign trial = (65'(src_root) << (K + 1)) | (65'd1 << (2 * K));
        assign take  = trial <= {1'b0, src_rem};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (en)
                vld_reg[s] <= src_vld;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ctx_reg[s]  <= src_ctx;
                rem_reg[s]  <= take ? 64'({1'b0, src_rem} - trial) : src_rem;
                root_reg[s] <= take ? (src_root | (32'd1 << K)) : src_root;
            end
        end
    end

    assign vld_out  = vld_reg[SQ_STAGES-1];
    assign ctx_out  = ctx_reg[SQ_STAGES-1];
    assign root_out = root_reg[SQ_STAGES-1];

endmodule

`default_nettype wire

// File: rtl/vau_div.sv
`default_nettype none

// three-lane restoring divider, |a| << FRAC_BITS over divisor, one quotient bit per stage
module vau_div import vau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int QW        = WORD_W + FRAC_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                vld_in,
    input  vau_ctx_t            ctx_in,
    input  logic [31:0]         div_in,
    output logic                vld_out,
    output vau_ctx_t            ctx_out,
    output logic [2:0][QW-1:0]  quo_out
);

    logic          vld_reg [QW];
    vau_ctx_t      ctx_reg [QW];
    logic [31:0]   div_reg [QW];
    logic [31:0]   rem_reg [QW][3];
    logic [QW-1:0] quo_reg [QW][3];

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        localparam int J = QW - 1 - s;
        logic        src_vld;
        vau_ctx_t    src_ctx;
        logic [31:0] src_div;

        if (s == 0)
        begin : g_first
            assign src_vld = vld_in;
            assign src_ctx = ctx_in;
            assign src_div = div_in;
        end
        else
        begin : g_next
            assign src_vld = vld_reg[s-1];
            assign src_ctx = ctx_reg[s-1];
            assign src_div = div_reg[s-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (en)
                vld_reg[s] <= src_vld;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ctx_reg[s] <= src_ctx;
                div_reg[s] <= src_div;
            end
        end

        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            logic [31:0]   src_rem;
            logic [QW-1:0] src_quo;
            logic          nbit;
            logic [32:0]   rem_sh;
            logic          ge;

            if (s == 0)
            begin : g_first
                assign src_rem = '0;
                assign src_quo = '0;
            end
            else
            begin : g_next
                assign src_rem = rem_reg[s-1][l];
                assign src_quo = quo_reg[s-1][l];
            end

            if (J >= FRAC_BITS)
            begin : g_dbit
                assign nbit = src_ctx.amag[l][J-FRAC_BITS];
            end
            else
            begin : g_zbit
                assign nbit = 1'b0;
            end

            assign rem_sh = {src_rem, nbit};
            assign ge     = rem_sh >= {1'b0, src_div};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s][l] <= ge ? 32'(rem_sh - {1'b0, src_div}) : rem_sh[31:0];
                    quo_reg[s][l] <= src_quo | (QW'(ge) << J);
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < 3; l++)
            quo_out[l] = quo_reg[QW-1][l];
    end

    assign vld_out = vld_reg[QW-1];
    assign ctx_out = ctx_reg[QW-1];

endmodule

`default_nettype wire
